@@ design/shamd_pkg.sv @@
package shamd_pkg;

	// Working variables and chaining value, entry 0 is variable a / word H0.
	typedef logic [7:0][31:0] hash_t;

	// Sequencer states of the digest block.
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_COMP = 6'b000010,
		S_FOLD = 6'b000100,
		S_PAD  = 6'b001000,
		S_LEN  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	localparam hash_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		unique case (r)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

@@ design/shamd_round.sv @@
module shamd_round (
	input  shamd_pkg::hash_t v,
	input  logic [31:0]      w0,
	input  logic [31:0]      w1,
	input  logic [31:0]      w9,
	input  logic [31:0]      w14,
	input  logic [31:0]      k,
	output shamd_pkg::hash_t v_next,
	output logic [31:0]      w_new
);
	import shamd_pkg::*;

	logic [31:0] big_s0, big_s1, ch, maj, t1, t2, sm0, sm1;

	// Message schedule: next word sixteen rounds ahead.
	assign sm0   = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
	assign sm1   = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
	assign w_new = sm1 + w9 + sm0 + w0;

	// One compression round.
	assign big_s1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
		^ {v[4][24:0], v[4][31:25]};
	assign big_s0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
		^ {v[0][21:0], v[0][31:22]};
	assign ch     = (v[4] & v[5]) ^ (~v[4] & v[6]);
	assign maj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
	assign t1     = v[7] + big_s1 + ch + k + w0;
	assign t2     = big_s0 + maj;

	always_comb begin
		v_next[7] = v[6];
		v_next[6] = v[5];
		v_next[5] = v[4];
		v_next[4] = v[3] + t1;
		v_next[3] = v[2];
		v_next[2] = v[1];
		v_next[1] = v[0];
		v_next[0] = t1 + t2;
	end

endmodule

@@ design/sha256_message_digest.sv @@
// Channel  Direction  Handshake           Payload
// in       sink       in_valid/in_stall   data_byte, has_byte, last
// out      source     out_valid/out_stall digest_word, word_index, last_word
//
// The 64th byte of a block starts a compression, the 64 rounds of S_COMP and then a fold into
// the chaining value in S_FOLD; in_stall stays high until the block is done.
// A last transfer adds a pad state and one compression, or two with a length state
// when eight or fewer bytes are left in the block, then eight output transfers.
// Reset loads the initial hash values and clears the byte and bit counters. A stall
// on the output holds the current digest word; no input is taken until all eight leave.
module sha256_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import shamd_pkg::*;

	state_t            state_q, after_q;
	hash_t             chain_q, v_q, v_next;
	logic [15:0][31:0] w_q;
	logic [31:0]       w_new;
	logic [5:0]        pos_q, pos_inc;
	logic [63:0]       bits_q;
	logic [5:0]        round_q;
	logic [2:0]        idx_q;
	logic              in_xfer, out_xfer;
	logic [3:0]        word_sel;
	logic [31:0]       byte_word, pad_word;

	// Merge a byte into the word at the current slot; a word's first byte clears it.
	function automatic logic [31:0] insert_byte(input logic [31:0] old,
		input logic [7:0] b, input logic [1:0] lane);
		logic [31:0] shifted;
		shifted = {b, 24'h0} >> {lane, 3'b000};
		return (lane == 2'd0) ? shifted : (old | shifted);
	endfunction

	assign in_stall    = (state_q != S_IDLE);
	assign in_xfer     = in_valid && !in_stall;
	assign out_valid   = (state_q == S_OUT);
	assign out_xfer    = out_valid && !out_stall;
	assign digest_word = chain_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);

	assign word_sel  = pos_q[5:2];
	assign pos_inc   = pos_q + 6'd1;
	assign byte_word = insert_byte(w_q[word_sel], data_byte, pos_q[1:0]);
	assign pad_word  = insert_byte(w_q[word_sel], PAD_BYTE, pos_q[1:0]);

	shamd_round u_round (
		.v      (v_q),
		.w0     (w_q[0]),
		.w1     (w_q[1]),
		.w9     (w_q[9]),
		.w14    (w_q[14]),
		.k      (round_k(round_q)),
		.v_next (v_next),
		.w_new  (w_new)
	);

	// Message words and working variables: payload, no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && has_byte) begin
					w_q[word_sel] <= byte_word;
				end
				// Load the working variables from the chaining value while idle, ready for a full block.
				v_q <= chain_q;
			end
			S_COMP: begin
				// Advance the schedule window by one word per round.
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i + 1];
				end
				w_q[15] <= w_new;
				v_q     <= v_next;
			end
			S_PAD: begin
				// Drop the pad byte in, zero the rest, and append the length if it fits.
				for (int i = 0; i < 16; i++) begin
					if (4'(i) == word_sel) begin
						w_q[i] <= pad_word;
					end else if (4'(i) > word_sel) begin
						if (pos_q[5:3] != 3'b111 && i == 14) begin
							w_q[i] <= bits_q[63:32];
						end else if (pos_q[5:3] != 3'b111 && i == 15) begin
							w_q[i] <= bits_q[31:0];
						end else begin
							w_q[i] <= 32'h0;
						end
					end
				end
				v_q <= chain_q;
			end
			S_LEN: begin
				for (int i = 0; i < 14; i++) begin
					w_q[i] <= 32'h0;
				end
				w_q[14] <= bits_q[63:32];
				w_q[15] <= bits_q[31:0];
				v_q     <= chain_q;
			end
			S_FOLD, S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			after_q <= S_IDLE;
			chain_q <= INIT_HASH;
			pos_q   <= 6'd0;
			bits_q  <= 64'd0;
			round_q <= 6'd0;
			idx_q   <= 3'd0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					round_q <= 6'd0;
					if (in_xfer) begin
						if (has_byte) begin
							pos_q  <= pos_inc;
							bits_q <= bits_q + 64'd8;
						end
						if (has_byte && pos_inc == 6'd0) begin
							state_q <= S_COMP;
							after_q <= last ? S_PAD : S_IDLE;
						end else if (last) begin
							state_q <= S_PAD;
						end
					end
				end
				S_COMP: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					state_q <= after_q;
				end
				S_PAD: begin
					round_q <= 6'd0;
					state_q <= S_COMP;
					after_q <= (pos_q[5:3] == 3'b111) ? S_LEN : S_OUT;
				end
				S_LEN: begin
					round_q <= 6'd0;
					state_q <= S_COMP;
					after_q <= S_OUT;
				end
				S_OUT: begin
					if (out_xfer) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							// Return to the initial hash for the next message.
							chain_q <= INIT_HASH;
							pos_q   <= 6'd0;
							bits_q  <= 64'd0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
